/* hw/rtl/mcopt_pkg.sv */
//------------------------------------------------------------------------------
// mcopt_pkg
// Types and constants shared by the multi-channel timer table.
//------------------------------------------------------------------------------
`default_nettype none

package mcopt_pkg;

  localparam int unsigned ID_W        = 16;
  localparam int unsigned CLK_W       = 40;
  localparam int unsigned PER_W       = 31;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned FIRE_W      = $clog2(MAX_RESULTS + 1);
  localparam int unsigned REM_STEPS   = CLK_W - 1;
  localparam int unsigned REM_CNT_W   = $clog2(REM_STEPS + 1);

  // command codes
  localparam logic [1:0] CMD_ONESHOT  = 2'd0;
  localparam logic [1:0] CMD_PERIODIC = 2'd1;
  localparam logic [1:0] CMD_CLEAR    = 2'd2;
  localparam logic [1:0] CMD_TICK     = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_SCHED     = 2'd0;
  localparam logic [1:0] KIND_CLEAR     = 2'd1;
  localparam logic [1:0] KIND_FIRED     = 2'd2;
  localparam logic [1:0] KIND_IDLE_TICK = 2'd3;

  typedef struct packed {
    logic [1:0]        command;
    logic signed [31:0] delay_us;
    logic [15:0]       target_id;
    logic [23:0]       tick_delta_us;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] timer_id;
    logic        periodic;
    logic        failed;
    logic        last;
  } res_t;

  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  id;
    logic [CLK_W-1:0] deadline;
    logic [PER_W-1:0] period;
  } entry_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_COMPACT,
    CELL_INSERT,
    CELL_KILL
  } cell_op_e;

  typedef struct packed {
    cell_op_e        op;
    logic [ID_W-1:0] cmp_id;
    entry_t          new_entry;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SCAN,
    ST_DIV,
    ST_FLUSH,
    ST_COMPACT
  } state_e;

endpackage

`default_nettype wire

/* hw/rtl/mcopt_cell.sv */
//------------------------------------------------------------------------------
// mcopt_cell
// One timer slot of the chain; shifts toward the head on rotate and compact.
//------------------------------------------------------------------------------
`default_nettype none

module mcopt_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mcopt_pkg::cell_ctrl_t ctrl_i,
  input  wire mcopt_pkg::entry_t   nbr_i,
  input  wire logic                prev_valid_i,
  input  wire logic                hole_i,
  output logic                     hole_o,
  output mcopt_pkg::entry_t        entry_o,
  output logic                     match_o
);
  import mcopt_pkg::*;

  logic   valid_q, valid_d;
  entry_t data_q, data_d;

  assign match_o = valid_q && (data_q.id == ctrl_i.cmp_id);
  // a hole at or below this cell pulls the upper neighbor down
  assign hole_o  = hole_i | ~valid_q;

  always_comb begin
    entry_o       = data_q;
    entry_o.valid = valid_q;
  end

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    case (ctrl_i.op)
      CELL_ROTATE: begin
        valid_d = nbr_i.valid;
        data_d  = nbr_i;
      end
      CELL_COMPACT: begin
        if (hole_i || !valid_q) begin
          valid_d = nbr_i.valid;
          data_d  = nbr_i;
        end
      end
      CELL_INSERT: begin
        if (!valid_q && prev_valid_i) begin
          valid_d = 1'b1;
          data_d  = ctrl_i.new_entry;
        end
      end
      CELL_KILL: begin
        if (match_o) valid_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

`default_nettype wire

/* hw/rtl/mcopt_rem.sv */
//------------------------------------------------------------------------------
// mcopt_rem
// Bit-serial restoring remainder of a 39-bit lag by a 31-bit period.
//------------------------------------------------------------------------------
`default_nettype none

module mcopt_rem (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [mcopt_pkg::REM_STEPS-1:0] dividend_i,
  input  wire logic [mcopt_pkg::PER_W-1:0]   divisor_i,
  output logic                               done_o,
  output logic [mcopt_pkg::PER_W-1:0]        rem_o
);
  import mcopt_pkg::*;

  logic [REM_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [REM_STEPS-1:0] quo_q;
  logic [PER_W-1:0]     div_q, rem_q;
  logic [PER_W:0]       trial;
  logic [PER_W-1:0]     rem_next;

  assign trial    = {rem_q, quo_q[REM_STEPS-1]};
  assign rem_next = (trial >= {1'b0, div_q}) ? PER_W'(trial - {1'b0, div_q})
                                             : trial[PER_W-1:0];
  assign done_o   = done_q;
  assign rem_o    = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= REM_CNT_W'(REM_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == REM_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[REM_STEPS-2:0], 1'b0};
      rem_q <= rem_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/multi_channel_oneshot_periodic_timer.sv */
//------------------------------------------------------------------------------
// multi_channel_oneshot_periodic_timer
// Table of one-shot and periodic timers on a 40-bit microsecond clock.
//------------------------------------------------------------------------------
// Usage: drive cmd_i and raise start_i; the command transfers at a clock edge
// where start_i is high and busy_o is low. Results leave on res_o, one per
// res_valid_o cycle; res_o.last marks the final one of a command. There is no
// back-pressure on results.
// Slots live in a chain of cells kept packed in scheduling order.
// Schedule: with the table full the reply is a failure and the block stays
// ready; otherwise it searches past each id already in use, then inserts.
// A clear replies and, when the id is found, stays busy to compact. A tick
// rotates the whole chain once, running the bit-serial remainder unit for
// each periodic timer that fires, then flushes and compacts. One command is
// in flight at a time.
// Reset: clock at zero, next id one, all slots free; no clearing pass.
//------------------------------------------------------------------------------
`default_nettype none

module multi_channel_oneshot_periodic_timer #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire mcopt_pkg::cmd_t cmd_i,
  output logic               busy_o,
  output logic               res_valid_o,
  output mcopt_pkg::res_t    res_o
);
  import mcopt_pkg::*;

  localparam int unsigned SCAN_W = $clog2(TIMER_SLOTS + 1);

  state_e              state_q, state_d;
  logic [CLK_W-1:0]    clock_q;
  logic [ID_W-1:0]     next_id_q, cand_q, cand_inc;
  logic [PER_W-1:0]    dly_q;
  logic                per_q;
  logic [SCAN_W-1:0]   scan_q;
  logic [FIRE_W-1:0]   fired_q;
  res_t                pend_q, res_q, emit_res, pend_res;
  logic                pend_v_q, res_v_q, emit, record;

  cell_ctrl_t          ctrl;
  entry_t              cells [TIMER_SLOTS];
  entry_t              tail;
  logic [TIMER_SLOTS-1:0] match, valid;
  logic [TIMER_SLOTS:0]   hole;

  logic                accept, full, hit, packed_ok, due, last_idx;
  logic [CLK_W-1:0]    behind, new_dl;
  logic                rem_start, rem_done;
  logic [PER_W-1:0]    rem;
  entry_t              head;

  // ---------------- cell chain ----------------
  assign hole[0] = 1'b0;
  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
    entry_t nbr;
    logic   prev_v;
    if (i == TIMER_SLOTS - 1) begin : g_tail
      assign nbr = tail;
    end else begin : g_mid
      assign nbr = cells[i+1];
    end
    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_rest
      assign prev_v = cells[i-1].valid;
    end
    mcopt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .nbr_i        (nbr),
      .prev_valid_i (prev_v),
      .hole_i       (hole[i]),
      .hole_o       (hole[i+1]),
      .entry_o      (cells[i]),
      .match_o      (match[i])
    );
    assign valid[i] = cells[i].valid;
  end

  always_comb begin
    packed_ok = 1'b1;
    for (int i = 0; i + 1 < TIMER_SLOTS; i++) begin
      if (!valid[i] && valid[i+1]) packed_ok = 1'b0;
    end
  end

  mcopt_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (behind[REM_STEPS-1:0]),
    .divisor_i  (head.period),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  // ---------------- shared terms ----------------
  assign accept   = start_i && (state_q == ST_IDLE);
  assign busy_o   = (state_q != ST_IDLE);
  assign head     = cells[0];
  assign full     = valid[TIMER_SLOTS-1];
  assign hit      = |match;
  assign behind   = clock_q - head.deadline;
  assign due      = head.valid && !behind[CLK_W-1] && (fired_q != FIRE_W'(MAX_RESULTS));
  assign last_idx = (scan_q == SCAN_W'(TIMER_SLOTS - 1));
  assign new_dl   = clock_q + CLK_W'(head.period) - CLK_W'(rem);
  assign cand_inc = (cand_q == {ID_W{1'b1}}) ? ID_W'(1) : cand_q + 1'b1;

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_i.command)
            CMD_ONESHOT, CMD_PERIODIC: if (!full) state_d = ST_SEARCH;
            CMD_CLEAR:                 if (hit) state_d = ST_COMPACT;
            default:                   state_d = ST_SCAN;
          endcase
        end
      end
      ST_SEARCH:  if (!hit) state_d = ST_IDLE;
      ST_SCAN: begin
        if (due && head.period != '0) state_d = ST_DIV;
        else if (last_idx)            state_d = ST_FLUSH;
      end
      ST_DIV:     if (rem_done) state_d = last_idx ? ST_FLUSH : ST_SCAN;
      ST_FLUSH:   state_d = ST_COMPACT;
      ST_COMPACT: if (packed_ok) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // ---------------- outputs and cell control ----------------
  always_comb begin
    ctrl.op        = CELL_HOLD;
    ctrl.cmp_id    = cand_q;
    ctrl.new_entry = '{valid: 1'b1, id: cand_q,
                       deadline: clock_q + CLK_W'(dly_q),
                       period: per_q ? dly_q : '0};
    tail      = head;
    emit      = 1'b0;
    emit_res  = '0;
    record    = 1'b0;
    pend_res  = '0;
    rem_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        ctrl.cmp_id = cmd_i.target_id;
        if (accept) begin
          case (cmd_i.command)
            CMD_ONESHOT, CMD_PERIODIC: begin
              if (full) begin
                emit     = 1'b1;
                emit_res = '{kind: KIND_SCHED, timer_id: '0, periodic: 1'b0,
                             failed: 1'b1, last: 1'b1};
              end
            end
            CMD_CLEAR: begin
              ctrl.op  = CELL_KILL;
              emit     = 1'b1;
              emit_res = '{kind: KIND_CLEAR, timer_id: cmd_i.target_id,
                           periodic: 1'b0, failed: !hit, last: 1'b1};
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        if (!hit) begin
          ctrl.op  = CELL_INSERT;
          emit     = 1'b1;
          emit_res = '{kind: KIND_SCHED, timer_id: cand_q,
                       periodic: per_q && (dly_q != '0), failed: 1'b0, last: 1'b1};
        end
      end
      ST_SCAN: begin
        if (due && head.period != '0) begin
          rem_start = 1'b1;
        end else begin
          ctrl.op = CELL_ROTATE;
          if (due) begin
            tail.valid = 1'b0;
            record     = 1'b1;
            pend_res   = '{kind: KIND_FIRED, timer_id: head.id, periodic: 1'b0,
                           failed: 1'b0, last: 1'b0};
          end
        end
      end
      ST_DIV: begin
        if (rem_done) begin
          ctrl.op       = CELL_ROTATE;
          tail.deadline = new_dl;
          record        = 1'b1;
          pend_res      = '{kind: KIND_FIRED, timer_id: head.id, periodic: 1'b1,
                            failed: 1'b0, last: 1'b0};
        end
      end
      ST_FLUSH: begin
        emit = 1'b1;
        if (pend_v_q) begin
          emit_res      = pend_q;
          emit_res.last = 1'b1;
        end else begin
          emit_res = '{kind: KIND_IDLE_TICK, timer_id: '0, periodic: 1'b0,
                       failed: 1'b0, last: 1'b1};
        end
      end
      ST_COMPACT: begin
        tail = '0;
        if (!packed_ok) ctrl.op = CELL_COMPACT;
      end
      default: ;
    endcase
    // a newly fired timer pushes out the one held back
    if (record && pend_v_q) begin
      emit     = 1'b1;
      emit_res = pend_q;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      clock_q   <= '0;
      next_id_q <= ID_W'(1);
      res_v_q   <= 1'b0;
      pend_v_q  <= 1'b0;
      scan_q    <= '0;
      fired_q   <= '0;
    end else begin
      state_q <= state_d;
      res_v_q <= emit;
      if (accept && cmd_i.command == CMD_TICK) begin
        clock_q  <= clock_q + CLK_W'(cmd_i.tick_delta_us);
        scan_q   <= '0;
        fired_q  <= '0;
        pend_v_q <= 1'b0;
      end
      if (state_q == ST_SEARCH && !hit) next_id_q <= cand_inc;
      if (ctrl.op == CELL_ROTATE) scan_q <= scan_q + 1'b1;
      if (record) begin
        pend_v_q <= 1'b1;
        fired_q  <= fired_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= emit_res;
    if (record) pend_q <= pend_res;
    if (accept) begin
      cand_q <= (next_id_q == '0) ? ID_W'(1) : next_id_q;
      dly_q  <= cmd_i.delay_us[31] ? '0 : cmd_i.delay_us[PER_W-1:0];
      per_q  <= (cmd_i.command == CMD_PERIODIC);
    end else if (state_q == ST_SEARCH && hit) begin
      cand_q <= cand_inc;
    end
  end

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

  // ---------------- assertions ----------------
  a_idle_packed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> packed_ok)
    else $error("timer table not packed while idle");

  a_fired_id : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KIND_FIRED |-> res_o.timer_id != '0)
    else $error("fired timer carries id zero");

  a_empty_tick_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KIND_IDLE_TICK |-> res_o.last)
    else $error("empty tick reply not marked last");

  a_rem_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_done |-> state_q == ST_DIV)
    else $error("remainder finished outside reload");

endmodule

`default_nettype wire

/* tb/tb.sv */
//------------------------------------------------------------------------------
// tb
// Checks the timer table against a predictor of its own: schedules, clears and
// ticks, with results compared field by field in order of arrival.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import mcopt_pkg::*;

  localparam int SLOTS = 16;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  cmd_t cmd_i = '0;
  logic busy_o;
  logic res_valid_o;
  res_t res_o;

  multi_channel_oneshot_periodic_timer #(.TIMER_SLOTS(SLOTS)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .cmd_i(cmd_i),
    .busy_o(busy_o), .res_valid_o(res_valid_o), .res_o(res_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predicted table state
  logic [39:0] now_us;
  logic [15:0] id_next;
  logic        t_act [SLOTS];
  logic [15:0] t_id [SLOTS];
  logic [39:0] t_dl [SLOTS];
  logic [31:0] t_per [SLOTS];

  res_t expected_results[$];
  int   errors = 0;
  int   idle_pct = 0;
  longint cycles = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void pack_table();
    int j;
    j = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (t_act[i]) begin
        t_id[j] = t_id[i]; t_dl[j] = t_dl[i]; t_per[j] = t_per[i];
        t_act[j] = 1'b1; j++;
      end
    end
    for (int i = j; i < SLOTS; i++) t_act[i] = 1'b0;
  endfunction

  function automatic bit id_busy(logic [15:0] id);
    for (int i = 0; i < SLOTS; i++) if (t_act[i] && t_id[i] == id) return 1;
    return 0;
  endfunction

  function automatic void push_res(logic [1:0] k, logic [15:0] id, logic p, logic f);
    res_t r;
    r.kind = k; r.timer_id = id; r.periodic = p; r.failed = f; r.last = 1'b0;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void predict_command(cmd_t c);
    int n, cnt;
    logic [31:0] d;
    logic [15:0] cand;
    logic [39:0] behind;
    logic [63:0] k;
    bit found;
    n = 0;
    if (c.command == CMD_ONESHOT || c.command == CMD_PERIODIC) begin
      d = c.delay_us[31] ? 32'd0 : c.delay_us;
      cnt = 0;
      while (cnt < SLOTS && t_act[cnt]) cnt++;
      if (cnt >= SLOTS) push_res(KIND_SCHED, 16'd0, 1'b0, 1'b1);
      else begin
        cand = id_next;
        for (int t = 0; t < SLOTS + 2; t++) begin
          if (cand == 0) cand = 16'd1;
          if (!id_busy(cand)) break;
          cand = cand + 16'd1;
        end
        id_next = cand + 16'd1;
        if (id_next == 0) id_next = 16'd1;
        t_act[cnt] = 1'b1; t_id[cnt] = cand;
        t_dl[cnt] = now_us + 40'(d);
        t_per[cnt] = (c.command == CMD_PERIODIC) ? d : 32'd0;
        push_res(KIND_SCHED, cand, t_per[cnt] != 0, 1'b0);
      end
      n = 1;
    end else if (c.command == CMD_CLEAR) begin
      found = 0;
      if (c.target_id != 0)
        for (int i = 0; i < SLOTS; i++)
          if (!found && t_act[i] && t_id[i] == c.target_id) begin
            t_act[i] = 1'b0; found = 1;
          end
      if (found) pack_table();
      push_res(KIND_CLEAR, c.target_id, 1'b0, !found);
      n = 1;
    end else begin
      now_us = now_us + 40'(c.tick_delta_us);
      for (int i = 0; i < SLOTS && n < MAX_RESULTS; i++) begin
        if (!t_act[i]) continue;
        behind = now_us - t_dl[i];
        if (behind[39]) continue;
        if (t_per[i] != 0) begin
          k = 64'(behind) / 64'(t_per[i]) + 1;
          t_dl[i] = t_dl[i] + 40'(k * 64'(t_per[i]));
          push_res(KIND_FIRED, t_id[i], 1'b1, 1'b0);
        end else begin
          t_act[i] = 1'b0;
          push_res(KIND_FIRED, t_id[i], 1'b0, 1'b0);
        end
        n++;
      end
      pack_table();
      if (n == 0) begin
        push_res(KIND_IDLE_TICK, 16'd0, 1'b0, 1'b0);
        n = 1;
      end
    end
    expected_results[$].last = 1'b1;
  endfunction

  // one command transfer, with a random gap in front
  task automatic send_command(cmd_t c);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_command(c);
  endtask

  task automatic send(logic [1:0] op, logic [31:0] d, logic [15:0] id, logic [23:0] dt);
    cmd_t c;
    c.command = op; c.delay_us = d; c.target_id = id; c.tick_delta_us = dt;
    send_command(c);
  endtask

  function automatic logic [15:0] some_id();
    int live;
    live = 0;
    for (int i = 0; i < SLOTS; i++) if (t_act[i]) live++;
    if (live > 0 && $urandom_range(3) != 0) return t_id[$urandom_range(live - 1)];
    return 16'($urandom);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_ni && res_valid_o) begin
      if (expected_results.size() == 0) report("result with nothing expected");
      else begin
        res_t e;
        e = expected_results.pop_front();
        if (res_o.kind !== e.kind) report($sformatf("kind %0d exp %0d", res_o.kind, e.kind));
        if (res_o.timer_id !== e.timer_id)
          report($sformatf("timer_id %0d exp %0d", res_o.timer_id, e.timer_id));
        if (res_o.periodic !== e.periodic) report("periodic flag");
        if (res_o.failed !== e.failed) report("failed flag");
        if (res_o.last !== e.last) report("last flag");
      end
    end
  end

  task automatic test_directed();
    send(CMD_TICK, 0, 0, 0);
    send(CMD_CLEAR, 0, 16'd0, 0);
    send(CMD_CLEAR, 0, 16'hFFFF, 0);
    send(CMD_ONESHOT, 32'h8000_0000, 0, 0);
    send(CMD_PERIODIC, 32'd0, 0, 0);
    send(CMD_PERIODIC, 32'd3, 0, 0);
    send(CMD_ONESHOT, 32'h7FFF_FFFF, 0, 0);
    send(CMD_PERIODIC, 32'h7FFF_FFFF, 0, 0);
    send(CMD_TICK, 0, 0, 24'd0);
    send(CMD_TICK, 0, 0, 24'hFF_FFFF);
    send(CMD_CLEAR, 0, 16'd4, 0);
    send(CMD_CLEAR, 0, 16'd4, 0);
    // fill the table past full
    for (int i = 0; i < 16; i++) send(CMD_PERIODIC, 32'd1, 0, 0);
    send(CMD_TICK, 0, 0, 24'd10);
    send(CMD_TICK, 0, 0, 24'd0);
  endtask

  task automatic test_clock_wrap();
    for (int i = 0; i < 20; i++) begin
      for (int s = 0; s < SLOTS; s++) if (t_act[s]) send(CMD_CLEAR, 0, t_id[0], 0);
      send(CMD_ONESHOT, 32'h7FFF_FFFF, 0, 0);
      send(CMD_PERIODIC, 32'($urandom_range(1000, 1)), 0, 0);
      for (int t = 0; t < 3; t++) send(CMD_TICK, 0, 0, 24'hFF_FFFF - 24'($urandom_range(9)));
    end
  endtask

  task automatic test_random(int count);
    int r;
    logic [31:0] d;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      case ($urandom_range(3))
        0: d = $urandom;
        1: d = 32'($urandom_range(2000));
        default: d = 32'($urandom_range(200));
      endcase
      if (r < 30) send(CMD_ONESHOT, d, 16'($urandom), 24'($urandom));
      else if (r < 50) send(CMD_PERIODIC, d, 16'($urandom), 24'($urandom));
      else if (r < 65) send(CMD_CLEAR, d, some_id(), 24'($urandom));
      else send(CMD_TICK, d, 16'($urandom),
                ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(300)));
    end
  endtask

  initial begin
    now_us = '0;
    id_next = 16'd1;
    for (int i = 0; i < SLOTS; i++) begin
      t_act[i] = 0; t_id[i] = 0; t_dl[i] = 0; t_per[i] = 0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_pct = 27;
    test_directed();
    test_clock_wrap();
    test_random(35);
    idle_pct = 55;
    test_random(35);
    idle_pct = 0;
    test_random(40);
    start_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
